// ===== design/msb_pkg.sv =====
// Masked sprite blitter package: operation codes, controller states and
// the command/status structs between controller and datapath.
// No dependencies.
package msb_pkg;

  localparam int PIX_LOG2 = 4;
  localparam int PIX_W    = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DRAW  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_REDUCE,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_SPILL_RD,
    ST_SPILL_WR,
    ST_FB_RD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic spr_wr;
    logic clr_wr;
    logic red_start;
    logic red_step;
    logic draw_init;
    logic main_rd;
    logic main_wr;
    logic spill_rd;
    logic spill_wr;
    logic next_word;
    logic fb_rd;
    logic out_load;
  } msb_cmd_t;

  typedef struct packed {
    op_e  op;
    logic sel_ok;
    logic widx_ok;
    logic clr_last;
    logic red_done;
    logic off_zero;
    logic word_last;
    logic out_full;
  } msb_stat_t;

endpackage

// ===== design/msb_ifs.sv =====
// Request and response channel interfaces of the masked sprite blitter.
// Valid/ready handshake; no dependencies.
interface msb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  sprite_sel;
  logic [4:0]  word_index;
  logic [15:0] color_bits;
  logic [15:0] alpha_bits;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [11:0] fb_address;
  logic        fill_white;

  modport source (
    output valid, op, sprite_sel, word_index, color_bits, alpha_bits,
           pos_x, pos_y, fb_address, fill_white,
    input  ready
  );
  modport sink (
    input  valid, op, sprite_sel, word_index, color_bits, alpha_bits,
           pos_x, pos_y, fb_address, fill_white,
    output ready
  );
endinterface

interface msb_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        data_valid;

  modport source (output valid, read_data, data_valid, input ready);
  modport sink   (input valid, read_data, data_valid, output ready);
endinterface

// ===== design/msb_ctrl.sv =====
// Masked sprite blitter controller: sequences one request at a time.
// Depends on msb_pkg.
module msb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  msb_pkg::msb_stat_t stat_i,
  output msb_pkg::msb_cmd_t  cmd_o
);
  import msb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat_i.op)
          OP_WRITE: begin
            cmd_o.spr_wr = stat_i.sel_ok & stat_i.widx_ok;
            state_d      = ST_RESP;
          end
          OP_CLEAR: state_d = ST_CLEAR;
          OP_DRAW: begin
            if (stat_i.sel_ok) begin
              cmd_o.red_start = 1'b1;
              state_d         = ST_REDUCE;
            end else begin
              state_d = ST_RESP;
            end
          end
          OP_READ: begin
            cmd_o.red_start = 1'b1;
            state_d         = ST_REDUCE;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_RESP;
        end
      end
      ST_REDUCE: begin
        if (stat_i.red_done) begin
          cmd_o.draw_init = 1'b1;
          state_d = (stat_i.op == OP_DRAW) ? ST_DRAW_RD : ST_FB_RD;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      ST_DRAW_RD: begin
        cmd_o.main_rd = 1'b1;
        state_d       = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        cmd_o.main_wr = 1'b1;
        if (stat_i.off_zero) begin
          cmd_o.next_word = 1'b1;
          state_d = stat_i.word_last ? ST_RESP : ST_DRAW_RD;
        end else begin
          state_d = ST_SPILL_RD;
        end
      end
      ST_SPILL_RD: begin
        cmd_o.spill_rd = 1'b1;
        state_d        = ST_SPILL_WR;
      end
      ST_SPILL_WR: begin
        cmd_o.spill_wr  = 1'b1;
        cmd_o.next_word = 1'b1;
        state_d = stat_i.word_last ? ST_RESP : ST_DRAW_RD;
      end
      ST_FB_RD: begin
        cmd_o.fb_rd = 1'b1;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (!stat_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/msb_dp.sv =====
// Masked sprite blitter datapath: request registers, address reduction,
// sprite and frame memories, merge logic and response register. Depends on msb_pkg.
module msb_dp #(
  parameter int SPRITE_COUNT    = 16,
  parameter int SPRITE_WORDS_X  = 2,
  parameter int SPRITE_ROWS     = 16,
  parameter int FB_WORDS_X_LOG2 = 4,
  parameter int FB_WORDS        = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         op_i,
  input  logic [3:0]         sprite_sel_i,
  input  logic [4:0]         word_index_i,
  input  logic [15:0]        color_bits_i,
  input  logic [15:0]        alpha_bits_i,
  input  logic [7:0]         pos_x_i,
  input  logic [7:0]         pos_y_i,
  input  logic [11:0]        fb_address_i,
  input  logic               fill_white_i,
  input  msb_pkg::msb_cmd_t  cmd_i,
  output msb_pkg::msb_stat_t stat_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [15:0]        read_data_o,
  output logic               data_valid_o
);
  import msb_pkg::*;

  localparam int SPRITE_WORDS = SPRITE_WORDS_X * SPRITE_ROWS;
  localparam int SPRITE_DEPTH = SPRITE_COUNT * SPRITE_WORDS;
  localparam int SA_W      = (SPRITE_DEPTH > 1) ? $clog2(SPRITE_DEPTH) : 1;
  localparam int SB_W      = SA_W + 4;
  localparam int FA_W      = $clog2(FB_WORDS);
  localparam int RAW_W     = (9 + FB_WORDS_X_LOG2 > 12) ? 9 + FB_WORDS_X_LOG2 : 12;
  localparam int RED_STEPS = 2;
  localparam int RC_W      = $clog2(RED_STEPS + 1);
  localparam int SH_W      = RAW_W + FA_W;
  localparam int RCP_W     = RAW_W + 2;
  localparam int PRD_W     = RAW_W + RCP_W;
  localparam int CX_W      = $clog2(SPRITE_WORDS_X + 1);
  localparam int RY_W      = $clog2(SPRITE_ROWS + 1);

  localparam logic [FA_W:0]     FB_LIMIT   = (FA_W + 1)'(FB_WORDS);
  localparam logic [FA_W:0]     ROW_STRIDE = (FA_W + 1)'((1 << FB_WORDS_X_LOG2) % FB_WORDS);
  localparam logic [FA_W:0]     ONE_STEP   = (FA_W + 1)'(1);
  localparam logic [RCP_W-1:0]  RECIP      =
    RCP_W'(((64'd1 << SH_W) + 64'(FB_WORDS) - 64'd1) / 64'(FB_WORDS));
  localparam logic [RC_W-1:0]   RED_FIRST  = RC_W'(RED_STEPS);
  localparam logic [FA_W-1:0]   FB_LAST    = FA_W'(FB_WORDS - 1);
  localparam logic [CX_W-1:0]   LAST_COL   = CX_W'(SPRITE_WORDS_X - 1);
  localparam logic [RY_W-1:0]   LAST_ROW   = RY_W'(SPRITE_ROWS - 1);

  function automatic logic [FA_W-1:0] wrap_add(logic [FA_W-1:0] a, logic [FA_W:0] b);
    logic [FA_W:0] s;
    s = {1'b0, a} + b;
    if (s >= FB_LIMIT) begin
      s = s - FB_LIMIT;
    end
    return s[FA_W-1:0];
  endfunction

  // Captured request
  op_e         op_q;
  logic [3:0]  sel_q;
  logic [4:0]  widx_q;
  logic [15:0] color_q, alpha_q;
  logic [7:0]  px_q, py_q;
  logic [11:0] fba_q;
  logic        white_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      sel_q   <= sprite_sel_i;
      widx_q  <= word_index_i;
      color_q <= color_bits_i;
      alpha_q <= alpha_bits_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      fba_q   <= fb_address_i;
      white_q <= fill_white_i;
    end
  end

  logic            sel_ok, widx_ok;
  logic [3:0]      off;
  logic [SB_W-1:0] base_full, wr_full;
  logic [SA_W-1:0] spr_base, spr_wr_idx;

  assign sel_ok     = (9'(sel_q) < 9'(SPRITE_COUNT));
  assign widx_ok    = (11'(widx_q) < 11'(SPRITE_WORDS));
  assign off        = px_q[3:0];
  assign base_full  = SB_W'(sel_q) * SB_W'(SPRITE_WORDS);
  assign wr_full    = base_full + SB_W'(widx_q);
  assign spr_base   = SA_W'(base_full);
  assign spr_wr_idx = SA_W'(wr_full);

  // Address reduction modulo FB_WORDS: reciprocal multiply for the quotient,
  // then multiply back and subtract
  logic [RAW_W-1:0] raw_addr, raw_q, quo_q, red_q;
  logic [PRD_W-1:0] prod;
  logic [RC_W-1:0]  red_cnt_q;

  assign raw_addr = (op_q == OP_READ) ? RAW_W'(fba_q)
                  : (RAW_W'(py_q) << FB_WORDS_X_LOG2) + RAW_W'(px_q[7:PIX_LOG2]);
  assign prod     = PRD_W'(raw_q) * PRD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.red_start) begin
      raw_q <= raw_addr;
    end else if (cmd_i.red_step) begin
      if (red_cnt_q == RED_FIRST) begin
        quo_q <= RAW_W'(prod >> SH_W);
      end else begin
        red_q <= raw_q - quo_q * RAW_W'(FB_LIMIT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q <= '0;
    end else if (cmd_i.red_start) begin
      red_cnt_q <= RED_FIRST;
    end else if (cmd_i.red_step) begin
      red_cnt_q <= red_cnt_q - RC_W'(1);
    end
  end

  // Draw walk: sprite index, column/row counters, frame addresses
  logic [FA_W-1:0] addr_q, row_q, addr_inc, row_nxt, clr_q;
  logic [CX_W-1:0] c_q;
  logic [RY_W-1:0] r_q;
  logic [SA_W-1:0] sidx_q;

  assign addr_inc = wrap_add(addr_q, ONE_STEP);
  assign row_nxt  = wrap_add(row_q, ROW_STRIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q   <= '0;
      r_q   <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.draw_init) begin
        c_q <= '0;
        r_q <= '0;
      end else if (cmd_i.next_word) begin
        if (c_q == LAST_COL) begin
          c_q <= '0;
          r_q <= r_q + RY_W'(1);
        end else begin
          c_q <= c_q + CX_W'(1);
        end
      end
      if (cmd_i.clr_wr) begin
        clr_q <= (clr_q == FB_LAST) ? '0 : clr_q + FA_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_init) begin
      addr_q <= FA_W'(red_q);
      row_q  <= FA_W'(red_q);
      sidx_q <= spr_base;
    end else if (cmd_i.next_word) begin
      sidx_q <= sidx_q + SA_W'(1);
      if (c_q == LAST_COL) begin
        row_q  <= row_nxt;
        addr_q <= row_nxt;
      end else begin
        addr_q <= addr_inc;
      end
    end
  end

  // Sprite memories
  logic [15:0] color_mem [SPRITE_DEPTH];
  logic [15:0] alpha_mem [SPRITE_DEPTH];
  logic [15:0] spr_col_q, spr_alp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.spr_wr) begin
      color_mem[spr_wr_idx] <= color_q;
      alpha_mem[spr_wr_idx] <= alpha_q;
    end
    if (cmd_i.main_rd) begin
      spr_col_q <= color_mem[sidx_q];
      spr_alp_q <= alpha_mem[sidx_q];
    end
  end

  // Frame memory, single port
  logic [15:0]     frame_mem [FB_WORDS];
  logic [15:0]     fb_rd_q, fb_wdata, main_wd, spill_wd;
  logic [FA_W-1:0] fb_addr;
  logic            fb_we, fb_re;
  logic [31:0]     col_sh, alp_sh;

  assign col_sh   = {spr_col_q, 16'h0000} >> off;
  assign alp_sh   = {spr_alp_q, 16'h0000} >> off;
  assign main_wd  = (col_sh[31:16] & alp_sh[31:16]) | (fb_rd_q & ~alp_sh[31:16]);
  assign spill_wd = (col_sh[15:0] & alp_sh[15:0]) | (fb_rd_q & ~alp_sh[15:0]);

  assign fb_we = cmd_i.clr_wr | cmd_i.main_wr | cmd_i.spill_wr;
  assign fb_re = cmd_i.main_rd | cmd_i.spill_rd | cmd_i.fb_rd;

  always_comb begin
    if (cmd_i.clr_wr) begin
      fb_addr = clr_q;
    end else if (cmd_i.spill_rd || cmd_i.spill_wr) begin
      fb_addr = addr_inc;
    end else begin
      fb_addr = addr_q;
    end
    if (cmd_i.clr_wr) begin
      fb_wdata = {PIX_W{white_q}};
    end else if (cmd_i.main_wr) begin
      fb_wdata = main_wd;
    end else begin
      fb_wdata = spill_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      frame_mem[fb_addr] <= fb_wdata;
    end
    if (fb_re) begin
      fb_rd_q <= frame_mem[fb_addr];
    end
  end

  // Response register
  logic        rsp_valid_q;
  logic [15:0] rd_data_q;
  logic        dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rd_data_q <= (op_q == OP_READ) ? fb_rd_q : '0;
      dv_q      <= (op_q == OP_READ);
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign read_data_o  = rd_data_q;
  assign data_valid_o = dv_q;

  assign stat_o.op        = op_q;
  assign stat_o.sel_ok    = sel_ok;
  assign stat_o.widx_ok   = widx_ok;
  assign stat_o.clr_last  = (clr_q == FB_LAST);
  assign stat_o.red_done  = (red_cnt_q == '0);
  assign stat_o.off_zero  = (off == 4'd0);
  assign stat_o.word_last = (c_q == LAST_COL) && (r_q == LAST_ROW);
  assign stat_o.out_full  = rsp_valid_q & ~rsp_ready_i;

endmodule

// ===== design/masked_sprite_blitter.sv =====
// Masked sprite blitter top level: one request in flight, result held in an
// output register. A draw walks the sprite words, each a read and a write of
// the frame memory, plus a spill read and write when pos_x is not word aligned;
// a clear writes all FB_WORDS words. Frame memory single port sets
// the draw rate. Reset idles the controller and empties the output register;
// memories are not cleared.
module masked_sprite_blitter #(
  parameter int SPRITE_COUNT    = 16,
  parameter int SPRITE_WORDS_X  = 2,
  parameter int SPRITE_ROWS     = 16,
  parameter int FB_WORDS_X_LOG2 = 4,
  parameter int FB_WORDS        = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msb_req_if.sink    req,
  msb_rsp_if.source  rsp
);
  import msb_pkg::*;

  msb_cmd_t  cmd;
  msb_stat_t stat;

  msb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  msb_dp #(
    .SPRITE_COUNT    (SPRITE_COUNT),
    .SPRITE_WORDS_X  (SPRITE_WORDS_X),
    .SPRITE_ROWS     (SPRITE_ROWS),
    .FB_WORDS_X_LOG2 (FB_WORDS_X_LOG2),
    .FB_WORDS        (FB_WORDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (req.op),
    .sprite_sel_i (req.sprite_sel),
    .word_index_i (req.word_index),
    .color_bits_i (req.color_bits),
    .alpha_bits_i (req.alpha_bits),
    .pos_x_i      (req.pos_x),
    .pos_y_i      (req.pos_y),
    .fb_address_i (req.fb_address),
    .fill_white_i (req.fill_white),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_valid_o  (rsp.valid),
    .rsp_ready_i  (rsp.ready),
    .read_data_o  (rsp.read_data),
    .data_valid_o (rsp.data_valid)
  );

endmodule

// ===== design/msb_checker.sv =====
// Port-level checker for the masked sprite blitter, bound to the top level.
// Depends on masked_sprite_blitter and its channel interfaces.
module msb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] read_data_i,
  input logic        data_valid_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(read_data_i) && $stable(data_valid_i))
    else $error("response payload changed while stalled");

  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !data_valid_i |-> read_data_i == 16'h0000)
    else $error("nonzero read_data without data_valid");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in progress");

endmodule

bind masked_sprite_blitter msb_checker u_msb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .read_data_i  (rsp.read_data),
  .data_valid_i (rsp.data_valid)
);

// ===== tb/sv/msb_blit_checker.sv =====
// Scoreboard for the masked sprite blitter: keeps its own sprite store and
// framebuffer, predicts the response of each request and compares it.
// Depends on msb_pkg and the msb_req_if / msb_rsp_if interfaces.
module msb_blit_checker (
  input  logic clk_i,
  input  logic rst_ni,
  msb_req_if   req,
  msb_rsp_if   rsp,
  output int   fail_count_o,
  output int   pending_o
);
  import msb_pkg::*;

  localparam int SPRITES   = 16;
  localparam int WORDS_X   = 2;
  localparam int ROWS      = 16;
  localparam int SPR_WORDS = WORDS_X * ROWS;
  localparam int ROW_LOG2  = 4;
  localparam int FB_DEPTH  = 4096;

  typedef struct {
    logic [15:0] data;
    logic        flag;
  } fb_rsp_t;

  logic [15:0] spr_color [SPRITES*SPR_WORDS];
  logic [15:0] spr_alpha [SPRITES*SPR_WORDS];
  logic [15:0] frame_mem [FB_DEPTH];
  fb_rsp_t     expected_rsp [$];
  int          fails = 0;
  int          waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  initial begin
    foreach (spr_color[i]) begin
      spr_color[i] = '0;
      spr_alpha[i] = '0;
    end
    foreach (frame_mem[i]) frame_mem[i] = '0;
  end

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void merge_word(int unsigned a, logic [31:0] c, logic [31:0] m);
    int unsigned i;
    logic [15:0] old;
    i = a % FB_DEPTH;
    old = frame_mem[i];
    frame_mem[i] = (c[15:0] & m[15:0]) | (old & ~m[15:0]);
  endfunction

  function automatic void blit_sprite(int unsigned s, logic [7:0] px, logic [7:0] py);
    int unsigned off, start, idx, a;
    logic [31:0] col, alp;
    off = px[3:0];
    start = (int'(py) << ROW_LOG2) + px[7:4];
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < WORDS_X; c++) begin
        idx = s * SPR_WORDS + r * WORDS_X + c;
        col = {16'h0, spr_color[idx]};
        alp = {16'h0, spr_alpha[idx]};
        a = start + (r << ROW_LOG2) + c;
        merge_word(a, col >> off, alp >> off);
        // bits pushed out on the right land in the next word
        if (off != 0) merge_word(a + 1, col << (16 - off), alp << (16 - off));
      end
    end
  endfunction

  function automatic fb_rsp_t predict_blit();
    fb_rsp_t     e;
    op_e         op;
    int unsigned sel, widx;
    op = op_e'(req.op);
    sel = req.sprite_sel;
    widx = req.word_index;
    e.data = '0;
    e.flag = 1'b0;
    case (op)
      OP_WRITE: begin
        if (sel < SPRITES && widx < SPR_WORDS) begin
          spr_color[sel*SPR_WORDS + widx] = req.color_bits;
          spr_alpha[sel*SPR_WORDS + widx] = req.alpha_bits;
        end
      end
      OP_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = req.fill_white ? 16'hFFFF : 16'h0000;
      end
      OP_DRAW: begin
        if (sel < SPRITES) blit_sprite(sel, req.pos_x, req.pos_y);
      end
      default: begin
        e.data = frame_mem[req.fb_address % FB_DEPTH];
        e.flag = 1'b1;
      end
    endcase
    return e;
  endfunction

  always @(posedge clk_i) begin
    fb_rsp_t e;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          report($sformatf("response with no request pending: data %h flag %b",
                           rsp.read_data, rsp.data_valid));
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.read_data !== e.data)
            report($sformatf("read_data got %h want %h", rsp.read_data, e.data));
          if (rsp.data_valid !== e.flag)
            report($sformatf("data_valid got %b want %b", rsp.data_valid, e.flag));
        end
      end
      if (req.valid && req.ready) expected_rsp.push_back(predict_blit());
      waiting = expected_rsp.size();
    end
  end

endmodule

// ===== tb/sv/tb_masked_sprite_blitter.sv =====
// Top of the masked sprite blitter testbench: clock, reset, request stimulus
// and response back-pressure; checking lives in msb_blit_checker.
// Depends on msb_pkg, msb_ifs and the masked_sprite_blitter RTL.
module tb_masked_sprite_blitter;
  import msb_pkg::*;

  typedef struct {
    op_e         op;
    logic [3:0]  sel;
    logic [4:0]  widx;
    logic [15:0] color;
    logic [15:0] alpha;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [11:0] addr;
    logic        fill;
  } blit_req_t;

  localparam int N_ITEMS = 1100;

  logic clk_i;
  logic rst_ni;
  int   fails, pending;
  int   n_sent = 0, n_writes = 0, n_clears = 0, n_draws = 0, n_unaligned = 0, n_reads = 0;
  int   tx_quiet = 0;
  logic rx_hold = 1'b0;
  logic [31:0] spr_written [16];

  msb_req_if req_ch ();
  msb_rsp_if rsp_ch ();

  masked_sprite_blitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  msb_blit_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(4 * 1_500_000);
    $display("masked_sprite_blitter verification failed");
    $finish;
  end

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic blit_req_t random_req();
    blit_req_t r;
    r.op    = op_e'($urandom_range(0, 3));
    r.sel   = 4'($urandom_range(0, 15));
    r.widx  = 5'($urandom_range(0, 31));
    r.color = 16'($urandom_range(0, 65535));
    r.alpha = 16'($urandom_range(0, 65535));
    r.px    = 8'($urandom_range(0, 255));
    r.py    = 8'($urandom_range(0, 255));
    r.addr  = 12'($urandom_range(0, 4095));
    r.fill  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic int pick_full_sprite();
    int full [$];
    for (int s = 0; s < 16; s++) if (&spr_written[s]) full.push_back(s);
    if (full.size() == 0) return -1;
    return full[$urandom_range(0, full.size() - 1)];
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(blit_req_t r);
    int gap;
    if (tx_quiet > 0) begin
      gap = 0;
      tx_quiet--;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 31) == 0) tx_quiet = $urandom_range(16, 48);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= r.op;
    req_ch.sprite_sel <= r.sel;
    req_ch.word_index <= r.widx;
    req_ch.color_bits <= r.color;
    req_ch.alpha_bits <= r.alpha;
    req_ch.pos_x      <= r.px;
    req_ch.pos_y      <= r.py;
    req_ch.fb_address <= r.addr;
    req_ch.fill_white <= r.fill;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic write_word(int s, int w, logic [15:0] c, logic [15:0] m);
    blit_req_t r;
    r = random_req();
    r.op = OP_WRITE;
    r.sel = 4'(s);
    r.widx = 5'(w);
    r.color = c;
    r.alpha = m;
    send_req(r);
    spr_written[s][w] = 1'b1;
    n_writes++;
  endtask

  task automatic clear_fb(logic white);
    blit_req_t r;
    r = random_req();
    r.op = OP_CLEAR;
    r.fill = white;
    send_req(r);
    n_clears++;
  endtask

  task automatic draw_at(int s, logic [7:0] px, logic [7:0] py);
    blit_req_t r;
    r = random_req();
    r.op = OP_DRAW;
    r.sel = 4'(s);
    r.px = px;
    r.py = py;
    send_req(r);
    n_draws++;
    if (px[3:0] != 0) n_unaligned++;
  endtask

  task automatic read_at(int unsigned a);
    blit_req_t r;
    r = random_req();
    r.op = OP_READ;
    r.addr = 12'(a % 4096);
    send_req(r);
    n_reads++;
  endtask

  // response side: random stall after each response outside quiet runs, plus the long hold-off
  initial begin
    int  stall;
    int  quiet;
    bit  fire;
    stall = 0;
    quiet = 0;
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      fire = rsp_ch.valid && rsp_ch.ready;
      @(negedge clk_i);
      if (fire) begin
        if (quiet > 0) begin
          quiet--;
        end else begin
          stall = $urandom_range(0, 12);
          if ($urandom_range(0, 31) == 0) quiet = $urandom_range(16, 48);
        end
      end
      if (rx_hold || stall > 0) begin
        rsp_ch.ready <= 1'b0;
        if (stall > 0) stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (n_sent >= 300);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    int          s, k, px, py;
    int unsigned start;
    foreach (spr_written[i]) spr_written[i] = '0;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_WRITE;
    req_ch.sprite_sel = '0;
    req_ch.word_index = '0;
    req_ch.color_bits = '0;
    req_ch.alpha_bits = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.fb_address = '0;
    req_ch.fill_white = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: clears, address extremes, sprite word extremes, draw corners
    clear_fb(1'b1);
    read_at(0);
    read_at(4095);
    clear_fb(1'b0);
    read_at(2048);
    write_word(0, 0, 16'hFFFF, 16'hFFFF);
    write_word(15, 31, 16'h0000, 16'hFFFF);
    write_word(0, 31, 16'h8001, 16'h0000);
    foreach (spr_written[i]) begin
      if (i == 0 || i == 15) begin
        for (int w = 0; w < 32; w++)
          if (!spr_written[i][w]) write_word(i, w, 16'($urandom_range(0, 65535)), rand_mask());
      end
    end
    clear_fb(1'b1);
    draw_at(0, 8'd0, 8'd0);
    read_at(0);
    read_at(1);
    read_at(2);
    draw_at(15, 8'd255, 8'd255);      // offset 15, wraps past the last word
    read_at(4095);
    read_at(0);
    read_at(15);
    draw_at(0, 8'd8, 8'd3);
    read_at(48);
    read_at(50);
    draw_at(15, 8'd240, 8'd17);       // aligned, second column runs into next row
    read_at(287);
    draw_at(0, 8'd241, 8'd17);
    read_at(288);
    read_at(289);

    while (n_sent < N_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 10 || pick_full_sprite() < 0) begin
        s = $urandom_range(0, 15);
        for (int w = 0; w < 32; w++)
          write_word(s, w, 16'($urandom_range(0, 65535)), rand_mask());
      end else if (k < 60) begin
        repeat ($urandom_range(1, 3)) begin
          s = pick_full_sprite();
          px = $urandom_range(0, 255);
          py = $urandom_range(0, 255);
          if ($urandom_range(0, 3) == 0) px = px & 8'hF0;
          if ($urandom_range(0, 6) == 0) py = $urandom_range(240, 255);
          draw_at(s, 8'(px), 8'(py));
          start = py * 16 + px / 16;
          repeat ($urandom_range(1, 4))
            read_at(start + $urandom_range(0, 15) * 16 + $urandom_range(0, 2));
        end
      end else if (k < 65) begin
        clear_fb(1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 3)) read_at($urandom_range(0, 4095));
      end else if (k < 80) begin
        repeat ($urandom_range(1, 4)) read_at($urandom_range(0, 4095));
      end else begin
        // stray and partial sprite writes
        repeat ($urandom_range(1, 6))
          write_word($urandom_range(0, 15), $urandom_range(0, 31),
                     16'($urandom_range(0, 65535)), rand_mask());
      end
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (64) @(negedge clk_i);
    $display("run covered %0d requests: %0d sprite writes, %0d clears, %0d reads",
             n_sent, n_writes, n_clears, n_reads);
    $display("draws: %0d, %0d of them not word aligned; mismatches: %0d",
             n_draws, n_unaligned, fails);
    if (fails == 0)
      $display("masked_sprite_blitter verification clean");
    else
      $display("masked_sprite_blitter verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/msb_pkg.sv
design/msb_ifs.sv
design/msb_ctrl.sv
design/msb_dp.sv
design/masked_sprite_blitter.sv
design/msb_checker.sv
tb/sv/msb_blit_checker.sv
tb/sv/tb_masked_sprite_blitter.sv
